### hw/rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// shared constants for the cylinder surface projection pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_INDEX_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CYL_RADIUS  = 8'd1;

    localparam longint unsigned HALF_LENGTH_RST = 64'd65536;
    localparam longint unsigned CYL_RADIUS_RST  = 64'd65536;

endpackage

### hw/rtl/cylinder_surface_projection.sv
// ----------------------------------------------------------------------------
// cylinder_surface_projection
// closest point on the surface of a closed z-aligned cylinder
//
// s_ channel takes one point per word (x, y, z, signed fixed point); m_
// channel returns the projected point in m_tdata and the inside flag in
// m_tuser, one result word per input word, in order.
// half_length and cyl_radius are written through cfg_we / cfg_index /
// cfg_wdata; unknown indexes are ignored. The user must write them only
// while no word is in flight; the block itself does not enforce this.
// The pipeline has three front stages, one stage per root bit of the square
// root, one decision stage, one stage per quotient bit of the divider and
// the output register. Throughput is one word per cycle while the receiver
// keeps up; the square root and divider are fully pipelined.
// Reset clears all valid bits and loads both registers with 1.0.
// When the receiver stalls, the skid entry catches one word and then the
// whole pipeline holds; s_tready drops only then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cylinder_surface_projection #(
    parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [csp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [COORD_WIDTH-2:0]               cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, pos_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // proj_x, proj_y, proj_z, zero fill
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    // is_inside
    output logic                                 m_tuser
);

    import csp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = ((3*CW+7)/8)*8;
    localparam int SQ_SB = 7*CW + 5;
    localparam int DV_SB = 3*CW + 6;

    logic [CW-2:0]   half_length_reg, cyl_radius_reg;
    logic            ce;

    logic            f_valid, f_sx, f_sy, f_sz, f_inz, f_inr;
    logic [2*CW-1:0] f_sum, f_prx, f_pry;
    logic [CW-1:0]   f_mx, f_my, f_mz;

    logic            q_valid;
    logic [CW-1:0]   q_root;
    logic [SQ_SB-1:0] q_sb;
    logic            q_sx, q_sy, q_sz, q_inz, q_inr;
    logic [CW-1:0]   q_mx, q_my, q_mz;
    logic [2*CW-1:0] q_prx, q_pry;

    logic [CW-1:0]   dz, dr, len_w, rad_w;
    logic            cap, wall;

    logic            d_vld_reg;
    logic [CW-1:0]   d_n_reg, d_mx_reg, d_my_reg, d_pz_reg;
    logic [2*CW-1:0] d_prx_reg, d_pry_reg;
    logic            d_wall_reg, d_nz_reg, d_sx_reg, d_sy_reg, d_sz_reg, d_in_reg;

    logic            v_valid;
    logic [CW-1:0]   v_qx, v_qy;
    logic [DV_SB-1:0] v_sb;
    logic            v_wall, v_nz, v_sx, v_sy, v_sz, v_in;
    logic [CW-1:0]   v_mx, v_my, v_pz;

    logic [CW-1:0]   px, py, ox, oy, oz;
    logic            sx, sy;
    logic [DW:0]     res_data, out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_length_reg <= (CW-1)'(HALF_LENGTH_RST);
            cyl_radius_reg  <= (CW-1)'(CYL_RADIUS_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HALF_LENGTH: half_length_reg <= cfg_wdata;
                REG_CYL_RADIUS:  cyl_radius_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    csp_front #(.CW(CW)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (s_tvalid && s_tready),
        .pos_x       (s_tdata[CW-1:0]),
        .pos_y       (s_tdata[2*CW-1:CW]),
        .pos_z       (s_tdata[3*CW-1:2*CW]),
        .half_length (half_length_reg),
        .cyl_radius  (cyl_radius_reg),
        .out_valid   (f_valid),
        .sum         (f_sum),
        .prod_x      (f_prx),
        .prod_y      (f_pry),
        .mag_x       (f_mx),
        .mag_y       (f_my),
        .mag_z       (f_mz),
        .sgn_x       (f_sx),
        .sgn_y       (f_sy),
        .sgn_z       (f_sz),
        .in_z        (f_inz),
        .in_r        (f_inr)
    );

    csp_isqrt #(.N(CW), .SBW(SQ_SB)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .radicand  (f_sum),
        .in_sb     ({f_sx, f_sy, f_sz, f_inz, f_inr, f_mx, f_my, f_mz, f_prx, f_pry}),
        .out_valid (q_valid),
        .root      (q_root),
        .out_sb    (q_sb)
    );

    assign {q_sx, q_sy, q_sz, q_inz, q_inr, q_mx, q_my, q_mz, q_prx, q_pry} = q_sb;

    // both differences are non-negative where the compare is used
    assign len_w = {1'b0, half_length_reg};
    assign rad_w = {1'b0, cyl_radius_reg};
    assign dz    = len_w - q_mz;
    assign dr    = rad_w - q_root;
    assign cap   = q_inr && q_inz && (dz < dr);
    assign wall  = !q_inr || (q_inz && !(dz < dr));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (ce) begin
            d_vld_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_n_reg    <= q_root;
            d_prx_reg  <= q_prx;
            d_pry_reg  <= q_pry;
            d_mx_reg   <= q_mx;
            d_my_reg   <= q_my;
            d_pz_reg   <= (cap || !q_inz) ? len_w : q_mz;
            // on a cap, zero height counts as the lower cap
            d_sz_reg   <= cap ? !(!q_sz && (q_mz != '0)) : q_sz;
            d_wall_reg <= wall;
            d_nz_reg   <= (q_root == '0);
            d_sx_reg   <= q_sx;
            d_sy_reg   <= q_sy;
            d_in_reg   <= q_inz && q_inr;
        end
    end

    csp_divider #(.N(CW), .SBW(DV_SB)) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (d_vld_reg),
        .num_a     (d_prx_reg),
        .num_b     (d_pry_reg),
        .den       (d_n_reg),
        .in_sb     ({d_wall_reg, d_nz_reg, d_sx_reg, d_sy_reg, d_sz_reg, d_in_reg,
                     d_mx_reg, d_my_reg, d_pz_reg}),
        .out_valid (v_valid),
        .quo_a     (v_qx),
        .quo_b     (v_qy),
        .out_sb    (v_sb)
    );

    assign {v_wall, v_nz, v_sx, v_sy, v_sz, v_in, v_mx, v_my, v_pz} = v_sb;

    always_comb begin
        px = v_mx;
        py = v_my;
        sx = v_sx;
        sy = v_sy;
        if (v_wall) begin
            if (v_nz) begin
                px = rad_w;
                py = '0;
                sx = 1'b0;
                sy = 1'b0;
            end else begin
                px = v_qx;
                py = v_qy;
            end
        end
    end

    assign ox = sx   ? (~px   + 1'b1) : px;
    assign oy = sy   ? (~py   + 1'b1) : py;
    assign oz = v_sz ? (~v_pz + 1'b1) : v_pz;

    assign res_data = {v_in, (DW)'({oz, oy, ox})};

    csp_skid #(.DW(DW+1)) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_valid),
        .in_data   (res_data),
        .in_ready  (ce),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign s_tready = ce;
    assign m_tdata  = out_data[DW-1:0];
    assign m_tuser  = out_data[DW];

endmodule

### hw/rtl/csp_front.sv
// ----------------------------------------------------------------------------
// csp_front
// magnitudes, squares, scaled products and inside tests, three stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_front #(
    parameter int CW = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  logic [CW-1:0]   pos_x,
    input  logic [CW-1:0]   pos_y,
    input  logic [CW-1:0]   pos_z,
    input  logic [CW-2:0]   half_length,
    input  logic [CW-2:0]   cyl_radius,
    output logic            out_valid,
    output logic [2*CW-1:0] sum,
    output logic [2*CW-1:0] prod_x,
    output logic [2*CW-1:0] prod_y,
    output logic [CW-1:0]   mag_x,
    output logic [CW-1:0]   mag_y,
    output logic [CW-1:0]   mag_z,
    output logic            sgn_x,
    output logic            sgn_y,
    output logic            sgn_z,
    output logic            in_z,
    output logic            in_r
);

    logic            v1_reg, v2_reg, v3_reg;
    logic [CW-1:0]   mx1_reg, my1_reg, mz1_reg, mx2_reg, my2_reg, mz2_reg;
    logic [CW-1:0]   mx3_reg, my3_reg, mz3_reg;
    logic [2:0]      s1_reg, s2_reg, s3_reg;
    logic            inz1_reg, inz2_reg, inz3_reg, inr3_reg;
    logic [2*CW-1:0] sqx2_reg, sqy2_reg, r2_2_reg, prx2_reg, pry2_reg;
    logic [2*CW-1:0] prx3_reg, pry3_reg, sum3_reg;
    logic [CW-1:0]   mx_next, my_next, mz_next;
    logic [2*CW-1:0] rad_w, sum_next;

    // magnitude in CW bits, the most negative value maps to 2^(CW-1)
    assign mx_next  = pos_x[CW-1] ? (~pos_x + 1'b1) : pos_x;
    assign my_next  = pos_y[CW-1] ? (~pos_y + 1'b1) : pos_y;
    assign mz_next  = pos_z[CW-1] ? (~pos_z + 1'b1) : pos_z;
    assign rad_w    = {{(CW+1){1'b0}}, cyl_radius};
    assign sum_next = sqx2_reg + sqy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx1_reg  <= mx_next;
            my1_reg  <= my_next;
            mz1_reg  <= mz_next;
            s1_reg   <= {pos_z[CW-1], pos_y[CW-1], pos_x[CW-1]};
            inz1_reg <= (mz_next <= {1'b0, half_length});

            sqx2_reg <= {{CW{1'b0}}, mx1_reg} * {{CW{1'b0}}, mx1_reg};
            sqy2_reg <= {{CW{1'b0}}, my1_reg} * {{CW{1'b0}}, my1_reg};
            r2_2_reg <= rad_w * rad_w;
            prx2_reg <= {{CW{1'b0}}, mx1_reg} * rad_w;
            pry2_reg <= {{CW{1'b0}}, my1_reg} * rad_w;
            mx2_reg  <= mx1_reg;
            my2_reg  <= my1_reg;
            mz2_reg  <= mz1_reg;
            s2_reg   <= s1_reg;
            inz2_reg <= inz1_reg;

            sum3_reg <= sum_next;
            inr3_reg <= (sum_next <= r2_2_reg);
            prx3_reg <= prx2_reg;
            pry3_reg <= pry2_reg;
            mx3_reg  <= mx2_reg;
            my3_reg  <= my2_reg;
            mz3_reg  <= mz2_reg;
            s3_reg   <= s2_reg;
            inz3_reg <= inz2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum3_reg;
    assign prod_x    = prx3_reg;
    assign prod_y    = pry3_reg;
    assign mag_x     = mx3_reg;
    assign mag_y     = my3_reg;
    assign mag_z     = mz3_reg;
    assign sgn_x     = s3_reg[0];
    assign sgn_y     = s3_reg[1];
    assign sgn_z     = s3_reg[2];
    assign in_z      = inz3_reg;
    assign in_r      = inr3_reg;

endmodule

### hw/rtl/csp_isqrt.sv
// ----------------------------------------------------------------------------
// csp_isqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_isqrt #(
    parameter int N   = 32,
    parameter int SBW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  logic [2*N-1:0]   radicand,
    input  logic [SBW-1:0]   in_sb,
    output logic             out_valid,
    output logic [N-1:0]     root,
    output logic [SBW-1:0]   out_sb
);

    logic [N+1:0]   rem_w  [0:N];
    logic [N-1:0]   root_w [0:N];
    logic [2*N-1:0] rad_w  [0:N];
    logic [SBW-1:0] sb_w   [0:N];
    logic           vld_w  [0:N];

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = radicand;
    assign sb_w[0]   = in_sb;
    assign vld_w[0]  = in_valid;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [N+1:0]   sh, trial;
        logic           take;
        logic [N+1:0]   rem_next, rem_reg;
        logic [N-1:0]   root_next, root_reg;
        logic [2*N-1:0] rad_reg;
        logic [SBW-1:0] sb_reg;
        logic           vld_reg;

        assign sh        = {rem_w[i][N-1:0], rad_w[i][2*N-1 -: 2]};
        assign trial     = {root_w[i], 2'b01};
        assign take      = (sh >= trial);
        assign rem_next  = take ? (sh - trial) : sh;
        assign root_next = {root_w[i][N-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (ce) begin
                vld_reg <= vld_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad_w[i][2*N-3:0], 2'b00};
                sb_reg   <= sb_w[i];
            end
        end

        assign rem_w[i+1]  = rem_reg;
        assign root_w[i+1] = root_reg;
        assign rad_w[i+1]  = rad_reg;
        assign sb_w[i+1]   = sb_reg;
        assign vld_w[i+1]  = vld_reg;
    end

    assign out_valid = vld_w[N];
    assign root      = root_w[N];
    assign out_sb    = sb_w[N];

endmodule

### hw/rtl/csp_divider.sv
// ----------------------------------------------------------------------------
// csp_divider
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_divider #(
    parameter int N   = 32,
    parameter int SBW = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  logic [2*N-1:0]   num_a,
    input  logic [2*N-1:0]   num_b,
    input  logic [N-1:0]     den,
    input  logic [SBW-1:0]   in_sb,
    output logic             out_valid,
    output logic [N-1:0]     quo_a,
    output logic [N-1:0]     quo_b,
    output logic [SBW-1:0]   out_sb
);

    logic [N-1:0]   ra_w [0:N];
    logic [N-1:0]   rb_w [0:N];
    logic [N-1:0]   la_w [0:N];
    logic [N-1:0]   lb_w [0:N];
    logic [N-1:0]   d_w  [0:N];
    logic [SBW-1:0] sb_w [0:N];
    logic           vld_w[0:N];

    assign ra_w[0]  = num_a[2*N-1:N];
    assign rb_w[0]  = num_b[2*N-1:N];
    assign la_w[0]  = num_a[N-1:0];
    assign lb_w[0]  = num_b[N-1:0];
    assign d_w[0]   = den;
    assign sb_w[0]  = in_sb;
    assign vld_w[0] = in_valid;

    // low part register shifts the dividend out and the quotient in
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [N:0]     sa, sb2;
        logic           ta, tb;
        logic [N-1:0]   ra_reg, rb_reg, la_reg, lb_reg, d_reg;
        logic [SBW-1:0] sb_reg;
        logic           vld_reg;

        assign sa  = {ra_w[i], la_w[i][N-1]};
        assign sb2 = {rb_w[i], lb_w[i][N-1]};
        assign ta  = (sa  >= {1'b0, d_w[i]});
        assign tb  = (sb2 >= {1'b0, d_w[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (ce) begin
                vld_reg <= vld_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                ra_reg <= ta ? N'(sa - {1'b0, d_w[i]}) : sa[N-1:0];
                rb_reg <= tb ? N'(sb2 - {1'b0, d_w[i]}) : sb2[N-1:0];
                la_reg <= {la_w[i][N-2:0], ta};
                lb_reg <= {lb_w[i][N-2:0], tb};
                d_reg  <= d_w[i];
                sb_reg <= sb_w[i];
            end
        end

        assign ra_w[i+1]  = ra_reg;
        assign rb_w[i+1]  = rb_reg;
        assign la_w[i+1]  = la_reg;
        assign lb_w[i+1]  = lb_reg;
        assign d_w[i+1]   = d_reg;
        assign sb_w[i+1]  = sb_reg;
        assign vld_w[i+1] = vld_reg;
    end

    assign out_valid = vld_w[N];
    assign quo_a     = la_w[N];
    assign quo_b     = lb_w[N];
    assign out_sb    = sb_w[N];

endmodule

### hw/rtl/csp_skid.sv
// ----------------------------------------------------------------------------
// csp_skid
// output register with one skid entry, registered ready toward the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csp_skid #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [DW-1:0] out_data_reg, skid_data_reg;
    logic          take, drain;

    assign take  = in_valid && !skid_valid_reg;
    assign drain = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (drain) begin
            out_valid_next  = skid_valid_reg || take;
            skid_valid_next = 1'b0;
        end else if (take) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (take && !drain) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
